FILE: design/sca_pkg.sv
package sca_pkg;

    localparam int FRAC_BITS_DEFAULT     = 16;
    localparam int TABLE_ENTRIES_DEFAULT = 16;
    localparam int COEF_FRAC_BITS        = 35;
    localparam int WORDS_PER_ENTRY       = 12;
    localparam int POLY_LEN              = 5;
    localparam int POLY_TOP              = 4;
    localparam int CFG_W                 = 31;

    localparam logic [CFG_W-1:0] PI_RESET     = 31'd205887;
    localparam logic [CFG_W-1:0] TWO_PI_RESET = 31'd411775;

    // configuration register indexes
    localparam logic CFG_PI     = 1'b0;
    localparam logic CFG_TWO_PI = 1'b1;

    // word index codes
    localparam logic [3:0] WIDX_COMMIT = 4'd11;
    localparam logic [3:0] WIDX_TRANS0 = 4'd9;

    // input kinds
    localparam logic ACT_XFORM = 1'b0;

    typedef enum logic [1:0] {
        RES_XFORM  = 2'd0,
        RES_STAGED = 2'd1,
        RES_COMMIT = 2'd2,
        RES_FULL   = 2'd3
    } res_t;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_LOAD, S_CHK, S_DIV, S_DFIX, S_ADJ1, S_ADJ2,
        S_SQ, S_SQW, S_H0, S_H1, S_H2, S_H3, S_H4,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_N0, S_N1, S_N2,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5,
        S_SCAN_START, S_SCAN_RD, S_SCAN_CMP,
        S_AF_START, S_AF_RD, S_AF_MUL, S_AF_ACC, S_AF_TRD, S_AF_TADD,
        S_STAGE, S_CDEC, S_COPY, S_KEYW, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OPA_X, OPA_XH, OPA_ACCL, OPA_ACCH, OPA_XPPI, OPA_XMPI,
        OPA_RAD, OPA_TMP, OPA_WORD
    } opa_t;

    typedef enum logic [3:0] {
        OPB_X, OPB_X2L, OPB_X2H, OPB_ACCL, OPB_ACCH, OPB_TR, OPB_NPROD,
        OPB_TRIG0, OPB_TRIG1, OPB_TRIG2, OPB_TRIG3, OPB_VEC
    } opb_t;

    typedef enum logic [4:0] {
        WB_NONE, WB_LOAD_ANG, WB_DIV_START, WB_DIV_STEP, WB_DIV_FIX,
        WB_ADJ1, WB_ADJ2, WB_X2, WB_SUM_SET, WB_SUM_ADD, WB_ACC, WB_TR,
        WB_TRIG, WB_TMP, WB_VX, WB_VY, WB_VZ,
        WB_SCAN_START, WB_SCAN_CMP, WB_AF_START, WB_AF_ACC, WB_AF_ROW,
        WB_STAGE, WB_TGT, WB_COPY, WB_COMMIT
    } wb_t;

    typedef enum logic [1:0] {
        ADDR_MAT, ADDR_TRANS, ADDR_COPY
    } addr_src_t;

    typedef struct packed {
        logic      capture;
        opa_t      mul_a;
        opb_t      mul_b;
        logic      mul_sgn;
        wb_t       wb;
        logic [1:0] sel;
        logic [2:0] coef_sel;
        addr_src_t addr_src;
        logic      load_out;
        res_t      out_code;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic action;
        logic widx_over;
        logic widx_last;
        logic need_div;
        logic div_last;
        logic hit_now;
        logic slot_last;
        logic hit;
        logic free_found;
        logic col_last;
        logic row_last;
        logic copy_last;
        logic out_free;
    } stat_t;

    function automatic logic signed [63:0] poly_coef(input logic [2:0] idx);
        logic signed [63:0] c;
        unique case (idx)
            3'd0:    c = -64'sd802;
            3'd1:    c = 64'sd86665;
            3'd2:    c = -64'sd5961589;
            3'd3:    c = 64'sd227491688;
            3'd4:    c = -64'sd3481369351;
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

endpackage

FILE: design/sca_ctrl.sv
module sca_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  sca_pkg::stat_t  st,
    output sca_pkg::cmd_t   cmd
);

    sca_pkg::state_t state_reg, state_next;
    logic [1:0]      k_reg, k_next;
    logic [2:0]      hc_reg, hc_next;
    sca_pkg::res_t   code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sca_pkg::S_IDLE;
            k_reg     <= 2'd0;
            hc_reg    <= 3'd0;
            code_reg  <= sca_pkg::RES_XFORM;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            hc_reg    <= hc_next;
            code_reg  <= code_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        hc_next    = hc_reg;
        code_next  = code_reg;
        unique case (state_reg)
            sca_pkg::S_IDLE:
                if (st.in_valid)
                    state_next = sca_pkg::S_DISPATCH;
            sca_pkg::S_DISPATCH:
            begin
                k_next = 2'd0;
                priority if (st.action == sca_pkg::ACT_XFORM)
                    state_next = sca_pkg::S_LOAD;
                else if (st.widx_over)
                begin
                    code_next  = sca_pkg::RES_STAGED;
                    state_next = sca_pkg::S_OUT;
                end
                else
                    state_next = sca_pkg::S_STAGE;
            end
            sca_pkg::S_LOAD: state_next = sca_pkg::S_CHK;
            sca_pkg::S_CHK:
                state_next = st.need_div ? sca_pkg::S_DIV : sca_pkg::S_ADJ1;
            sca_pkg::S_DIV:
                if (st.div_last)
                    state_next = sca_pkg::S_DFIX;
            sca_pkg::S_DFIX: state_next = sca_pkg::S_ADJ1;
            sca_pkg::S_ADJ1: state_next = sca_pkg::S_ADJ2;
            sca_pkg::S_ADJ2: state_next = sca_pkg::S_SQ;
            sca_pkg::S_SQ:   state_next = sca_pkg::S_SQW;
            sca_pkg::S_SQW:
            begin
                hc_next    = 3'd0;
                state_next = sca_pkg::S_H0;
            end
            sca_pkg::S_H0: state_next = sca_pkg::S_H1;
            sca_pkg::S_H1: state_next = sca_pkg::S_H2;
            sca_pkg::S_H2: state_next = sca_pkg::S_H3;
            sca_pkg::S_H3: state_next = sca_pkg::S_H4;
            sca_pkg::S_H4:
            begin
                hc_next = hc_reg + 3'd1;
                state_next = (hc_reg == 3'(sca_pkg::POLY_LEN - 1)) ?
                             sca_pkg::S_T0 : sca_pkg::S_H0;
            end
            sca_pkg::S_T0: state_next = sca_pkg::S_T1;
            sca_pkg::S_T1: state_next = sca_pkg::S_T2;
            sca_pkg::S_T2: state_next = sca_pkg::S_T3;
            sca_pkg::S_T3: state_next = sca_pkg::S_T4;
            sca_pkg::S_T4: state_next = sca_pkg::S_N0;
            sca_pkg::S_N0: state_next = sca_pkg::S_N1;
            sca_pkg::S_N1: state_next = sca_pkg::S_N2;
            sca_pkg::S_N2:
            begin
                k_next = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? sca_pkg::S_C0 : sca_pkg::S_LOAD;
            end
            sca_pkg::S_C0: state_next = sca_pkg::S_C1;
            sca_pkg::S_C1: state_next = sca_pkg::S_C2;
            sca_pkg::S_C2: state_next = sca_pkg::S_C3;
            sca_pkg::S_C3: state_next = sca_pkg::S_C4;
            sca_pkg::S_C4: state_next = sca_pkg::S_C5;
            sca_pkg::S_C5: state_next = sca_pkg::S_SCAN_START;
            sca_pkg::S_SCAN_START: state_next = sca_pkg::S_SCAN_RD;
            sca_pkg::S_SCAN_RD:    state_next = sca_pkg::S_SCAN_CMP;
            sca_pkg::S_SCAN_CMP:
            begin
                if (st.hit_now || st.slot_last)
                begin
                    priority if (st.action != sca_pkg::ACT_XFORM)
                        state_next = sca_pkg::S_CDEC;
                    else if (st.hit_now)
                        state_next = sca_pkg::S_AF_START;
                    else
                    begin
                        code_next  = sca_pkg::RES_XFORM;
                        state_next = sca_pkg::S_OUT;
                    end
                end
                else
                    state_next = sca_pkg::S_SCAN_RD;
            end
            sca_pkg::S_AF_START: state_next = sca_pkg::S_AF_RD;
            sca_pkg::S_AF_RD:    state_next = sca_pkg::S_AF_MUL;
            sca_pkg::S_AF_MUL:   state_next = sca_pkg::S_AF_ACC;
            sca_pkg::S_AF_ACC:
                state_next = st.col_last ? sca_pkg::S_AF_TRD : sca_pkg::S_AF_RD;
            sca_pkg::S_AF_TRD:   state_next = sca_pkg::S_AF_TADD;
            sca_pkg::S_AF_TADD:
            begin
                if (st.row_last)
                begin
                    code_next  = sca_pkg::RES_XFORM;
                    state_next = sca_pkg::S_OUT;
                end
                else
                    state_next = sca_pkg::S_AF_RD;
            end
            sca_pkg::S_STAGE:
            begin
                if (st.widx_last)
                    state_next = sca_pkg::S_SCAN_START;
                else
                begin
                    code_next  = sca_pkg::RES_STAGED;
                    state_next = sca_pkg::S_OUT;
                end
            end
            sca_pkg::S_CDEC:
            begin
                if (st.hit || st.free_found)
                    state_next = sca_pkg::S_COPY;
                else
                begin
                    code_next  = sca_pkg::RES_FULL;
                    state_next = sca_pkg::S_OUT;
                end
            end
            sca_pkg::S_COPY:
                if (st.copy_last)
                    state_next = sca_pkg::S_KEYW;
            sca_pkg::S_KEYW:
            begin
                code_next  = sca_pkg::RES_COMMIT;
                state_next = sca_pkg::S_OUT;
            end
            sca_pkg::S_OUT:
                if (st.out_free)
                    state_next = sca_pkg::S_IDLE;
            default: state_next = sca_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.mul_a    = sca_pkg::OPA_X;
        cmd.mul_b    = sca_pkg::OPB_X;
        cmd.wb       = sca_pkg::WB_NONE;
        cmd.addr_src = sca_pkg::ADDR_MAT;
        cmd.out_code = code_reg;
        cmd.sel      = k_reg;
        cmd.coef_sel = hc_reg;
        unique case (state_reg)
            sca_pkg::S_IDLE:     cmd.capture = 1'b1;
            sca_pkg::S_DISPATCH: ;
            sca_pkg::S_LOAD:     cmd.wb = sca_pkg::WB_LOAD_ANG;
            sca_pkg::S_CHK:
                if (st.need_div)
                    cmd.wb = sca_pkg::WB_DIV_START;
            sca_pkg::S_DIV:      cmd.wb = sca_pkg::WB_DIV_STEP;
            sca_pkg::S_DFIX:     cmd.wb = sca_pkg::WB_DIV_FIX;
            sca_pkg::S_ADJ1:     cmd.wb = sca_pkg::WB_ADJ1;
            sca_pkg::S_ADJ2:     cmd.wb = sca_pkg::WB_ADJ2;
            sca_pkg::S_SQ:
                cmd.mul_sgn = 1'b1;
            sca_pkg::S_SQW:      cmd.wb = sca_pkg::WB_X2;
            sca_pkg::S_H0:
            begin
                cmd.mul_a = sca_pkg::OPA_ACCL;
                cmd.mul_b = sca_pkg::OPB_X2L;
            end
            sca_pkg::S_H1:
            begin
                cmd.mul_a = sca_pkg::OPA_ACCH;
                cmd.mul_b = sca_pkg::OPB_X2L;
                cmd.wb    = sca_pkg::WB_SUM_SET;
            end
            sca_pkg::S_H2:
            begin
                cmd.mul_a = sca_pkg::OPA_ACCL;
                cmd.mul_b = sca_pkg::OPB_X2H;
                cmd.wb    = sca_pkg::WB_SUM_ADD;
            end
            sca_pkg::S_H3:       cmd.wb = sca_pkg::WB_SUM_ADD;
            sca_pkg::S_H4:       cmd.wb = sca_pkg::WB_ACC;
            sca_pkg::S_T0:
                cmd.mul_b = sca_pkg::OPB_ACCL;
            sca_pkg::S_T1:
            begin
                cmd.mul_a = sca_pkg::OPA_XH;
                cmd.mul_b = sca_pkg::OPB_ACCL;
                cmd.wb    = sca_pkg::WB_SUM_SET;
            end
            sca_pkg::S_T2:
            begin
                cmd.mul_b = sca_pkg::OPB_ACCH;
                cmd.wb    = sca_pkg::WB_SUM_ADD;
            end
            sca_pkg::S_T3:       cmd.wb = sca_pkg::WB_SUM_ADD;
            sca_pkg::S_T4:       cmd.wb = sca_pkg::WB_TR;
            sca_pkg::S_N0:
            begin
                cmd.mul_a   = sca_pkg::OPA_XPPI;
                cmd.mul_b   = sca_pkg::OPB_TR;
                cmd.mul_sgn = 1'b1;
            end
            sca_pkg::S_N1:
            begin
                cmd.mul_a   = sca_pkg::OPA_XMPI;
                cmd.mul_b   = sca_pkg::OPB_NPROD;
                cmd.mul_sgn = 1'b1;
            end
            sca_pkg::S_N2:       cmd.wb = sca_pkg::WB_TRIG;
            sca_pkg::S_C0:
            begin
                cmd.mul_a   = sca_pkg::OPA_RAD;
                cmd.mul_b   = sca_pkg::OPB_TRIG0;
                cmd.mul_sgn = 1'b1;
            end
            sca_pkg::S_C1:       cmd.wb = sca_pkg::WB_TMP;
            sca_pkg::S_C2:
            begin
                cmd.mul_a   = sca_pkg::OPA_TMP;
                cmd.mul_b   = sca_pkg::OPB_TRIG1;
                cmd.mul_sgn = 1'b1;
            end
            sca_pkg::S_C3:
            begin
                cmd.mul_a   = sca_pkg::OPA_TMP;
                cmd.mul_b   = sca_pkg::OPB_TRIG2;
                cmd.mul_sgn = 1'b1;
                cmd.wb      = sca_pkg::WB_VX;
            end
            sca_pkg::S_C4:
            begin
                cmd.mul_a   = sca_pkg::OPA_RAD;
                cmd.mul_b   = sca_pkg::OPB_TRIG3;
                cmd.mul_sgn = 1'b1;
                cmd.wb      = sca_pkg::WB_VY;
            end
            sca_pkg::S_C5:         cmd.wb = sca_pkg::WB_VZ;
            sca_pkg::S_SCAN_START: cmd.wb = sca_pkg::WB_SCAN_START;
            sca_pkg::S_SCAN_RD:    ;
            sca_pkg::S_SCAN_CMP:   cmd.wb = sca_pkg::WB_SCAN_CMP;
            sca_pkg::S_AF_START:   cmd.wb = sca_pkg::WB_AF_START;
            sca_pkg::S_AF_RD:      ;
            sca_pkg::S_AF_MUL:
            begin
                cmd.mul_a   = sca_pkg::OPA_WORD;
                cmd.mul_b   = sca_pkg::OPB_VEC;
                cmd.mul_sgn = 1'b1;
            end
            sca_pkg::S_AF_ACC:     cmd.wb = sca_pkg::WB_AF_ACC;
            sca_pkg::S_AF_TRD:     cmd.addr_src = sca_pkg::ADDR_TRANS;
            sca_pkg::S_AF_TADD:    cmd.wb = sca_pkg::WB_AF_ROW;
            sca_pkg::S_STAGE:      cmd.wb = sca_pkg::WB_STAGE;
            sca_pkg::S_CDEC:
                if (st.hit || st.free_found)
                    cmd.wb = sca_pkg::WB_TGT;
            sca_pkg::S_COPY:
            begin
                cmd.addr_src = sca_pkg::ADDR_COPY;
                cmd.wb       = sca_pkg::WB_COPY;
            end
            sca_pkg::S_KEYW:       cmd.wb = sca_pkg::WB_COMMIT;
            sca_pkg::S_OUT:        cmd.load_out = st.out_free;
            default: ;
        endcase
    end

endmodule

FILE: design/sca_dp.sv
module sca_dp #(
    parameter int FRAC_BITS     = sca_pkg::FRAC_BITS_DEFAULT,
    parameter int TABLE_ENTRIES = sca_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sca_pkg::cmd_t            cmd,
    output sca_pkg::stat_t           st,
    input  logic                     in_valid,
    input  logic                     in_action,
    input  logic [31:0]              in_key,
    input  logic signed [31:0]       in_radius,
    input  logic signed [31:0]       in_phi,
    input  logic signed [31:0]       in_theta,
    input  logic [3:0]               in_word_index,
    input  logic signed [31:0]       in_word_value,
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [sca_pkg::CFG_W-1:0] cfg_wdata,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [31:0]       out_x,
    output logic signed [31:0]       out_y,
    output logic signed [31:0]       out_z,
    output logic                     out_matched,
    output logic [1:0]               out_status
);

    localparam int SW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int WORDS = TABLE_ENTRIES * sca_pkg::WORDS_PER_ENTRY;
    localparam int AW    = $clog2(WORDS);
    localparam int WPE   = sca_pkg::WORDS_PER_ENTRY;

    // captured item
    logic              act_reg;
    logic [31:0]       key_reg, rad_reg, phi_reg, theta_reg, wval_reg;
    logic [3:0]        widx_reg;

    logic [sca_pkg::CFG_W-1:0] pi_reg, tpi_reg;

    logic [31:0] ang_reg, tr_reg, tmp_reg, racc_reg;
    logic [63:0] x2_reg, acc_reg, sum_reg, prod_reg;
    logic [31:0] trig_reg [4];
    logic [31:0] vec_reg [3];
    logic [31:0] res_reg [3];

    logic [31:0] rem_reg, dvd_reg;
    logic [4:0]  dcnt_reg;
    logic        neg_reg;

    logic [SW-1:0]            slot_reg, tgt_reg, free_reg;
    logic                     hit_reg, free_found_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0]              key_rd_reg, word_rd_reg;
    logic [1:0]               row_reg, col_reg;
    logic [3:0]               cnt_reg;
    logic [31:0]              stage_reg [WPE];

    logic [31:0] key_mem  [TABLE_ENTRIES];
    logic [31:0] word_mem [WORDS];

    logic        out_valid_reg, out_matched_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_x_reg, out_y_reg, out_z_reg;

    logic [31:0] pi32, half_pi, xppi, xmpi, nprod, opa, opb, ang_sel;
    logic [32:0] ang33, shifted;
    logic        ge_p, le_np, match;
    logic [63:0] sum_add;
    logic [3:0]  offs;
    logic [AW-1:0] word_addr;
    logic signed [32:0] ma, mb;

    assign pi32    = {1'b0, pi_reg};
    assign half_pi = {2'b00, pi_reg[sca_pkg::CFG_W-1:1]};
    assign xppi    = ang_reg + pi32;
    assign xmpi    = ang_reg - pi32;
    assign nprod   = prod_reg[FRAC_BITS +: 32];
    assign ang33   = {ang_reg[31], ang_reg};
    assign ge_p    = $signed(ang33) >= $signed({2'b00, pi_reg});
    assign le_np   = $signed(ang33) <= -$signed({2'b00, pi_reg});
    assign shifted = {rem_reg, dvd_reg[31]};
    assign sum_add = sum_reg + {prod_reg[31:0], 32'd0};
    assign match   = valid_reg[slot_reg] && (key_rd_reg == key_reg);

    always_comb
    begin
        unique case (cmd.sel)
            2'd0: ang_sel = theta_reg;
            2'd1: ang_sel = phi_reg + half_pi;
            2'd2: ang_sel = phi_reg;
            2'd3: ang_sel = theta_reg + half_pi;
            default: ang_sel = theta_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.addr_src)
            sca_pkg::ADDR_MAT:   offs = 4'({row_reg, 1'b0}) + 4'(row_reg) + 4'(col_reg);
            sca_pkg::ADDR_TRANS: offs = sca_pkg::WIDX_TRANS0 + 4'(row_reg);
            sca_pkg::ADDR_COPY:  offs = cnt_reg;
            default:             offs = cnt_reg;
        endcase
        word_addr = AW'({tgt_reg, 3'b000}) + AW'({tgt_reg, 2'b00}) + AW'(offs);
    end

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.mul_a)
            sca_pkg::OPA_X:    opa = ang_reg;
            sca_pkg::OPA_XH:   opa = {32{ang_reg[31]}};
            sca_pkg::OPA_ACCL: opa = acc_reg[31:0];
            sca_pkg::OPA_ACCH: opa = acc_reg[63:32];
            sca_pkg::OPA_XPPI: opa = xppi;
            sca_pkg::OPA_XMPI: opa = xmpi;
            sca_pkg::OPA_RAD:  opa = rad_reg;
            sca_pkg::OPA_TMP:  opa = tmp_reg;
            sca_pkg::OPA_WORD: opa = word_rd_reg;
            default:           opa = ang_reg;
        endcase
        unique case (cmd.mul_b)
            sca_pkg::OPB_X:     opb = ang_reg;
            sca_pkg::OPB_X2L:   opb = x2_reg[31:0];
            sca_pkg::OPB_X2H:   opb = x2_reg[63:32];
            sca_pkg::OPB_ACCL:  opb = acc_reg[31:0];
            sca_pkg::OPB_ACCH:  opb = acc_reg[63:32];
            sca_pkg::OPB_TR:    opb = tr_reg;
            sca_pkg::OPB_NPROD: opb = nprod;
            sca_pkg::OPB_TRIG0: opb = trig_reg[0];
            sca_pkg::OPB_TRIG1: opb = trig_reg[1];
            sca_pkg::OPB_TRIG2: opb = trig_reg[2];
            sca_pkg::OPB_TRIG3: opb = trig_reg[3];
            sca_pkg::OPB_VEC:   opb = vec_reg[col_reg];
            default:            opb = ang_reg;
        endcase
        ma = {cmd.mul_sgn & opa[31], opa};
        mb = {cmd.mul_sgn & opb[31], opb};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(ma * mb);
    end

    // tables
    always_ff @(posedge clk)
    begin
        if (cmd.wb == sca_pkg::WB_COMMIT)
            key_mem[tgt_reg] <= key_reg;
        key_rd_reg <= key_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wb == sca_pkg::WB_COPY)
            word_mem[word_addr] <= stage_reg[cnt_reg];
        word_rd_reg <= word_mem[word_addr];
    end

    // control state, configuration and staged words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_reg         <= sca_pkg::PI_RESET;
            tpi_reg        <= sca_pkg::TWO_PI_RESET;
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dcnt_reg       <= 5'd0;
            cnt_reg        <= 4'd0;
            row_reg        <= 2'd0;
            col_reg        <= 2'd0;
            slot_reg       <= '0;
            for (int i = 0; i < WPE; i++)
                stage_reg[i] <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == sca_pkg::CFG_PI)
                    pi_reg <= cfg_wdata;
                else
                    tpi_reg <= cfg_wdata;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.wb)
                sca_pkg::WB_DIV_START: dcnt_reg <= 5'd0;
                sca_pkg::WB_DIV_STEP:  dcnt_reg <= dcnt_reg + 5'd1;
                sca_pkg::WB_SCAN_START:
                begin
                    slot_reg       <= '0;
                    hit_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                sca_pkg::WB_SCAN_CMP:
                begin
                    if (match)
                        hit_reg <= 1'b1;
                    else if (!valid_reg[slot_reg] && !free_found_reg)
                        free_found_reg <= 1'b1;
                    if (slot_reg != SW'(TABLE_ENTRIES - 1))
                        slot_reg <= slot_reg + SW'(1);
                end
                sca_pkg::WB_AF_START:
                begin
                    row_reg <= 2'd0;
                    col_reg <= 2'd0;
                end
                sca_pkg::WB_AF_ACC: col_reg <= col_reg + 2'd1;
                sca_pkg::WB_AF_ROW:
                begin
                    row_reg <= row_reg + 2'd1;
                    col_reg <= 2'd0;
                end
                sca_pkg::WB_STAGE:  stage_reg[widx_reg] <= wval_reg;
                sca_pkg::WB_TGT:    cnt_reg <= 4'd0;
                sca_pkg::WB_COPY:   cnt_reg <= cnt_reg + 4'd1;
                sca_pkg::WB_COMMIT: valid_reg[tgt_reg] <= 1'b1;
                default: ;
            endcase
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_valid)
        begin
            act_reg   <= in_action;
            key_reg   <= in_key;
            rad_reg   <= in_radius;
            phi_reg   <= in_phi;
            theta_reg <= in_theta;
            widx_reg  <= in_word_index;
            wval_reg  <= in_word_value;
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= cmd.out_code;
            out_matched_reg <= (cmd.out_code == sca_pkg::RES_XFORM) && hit_reg;
            if (cmd.out_code != sca_pkg::RES_XFORM)
            begin
                out_x_reg <= 32'd0;
                out_y_reg <= 32'd0;
                out_z_reg <= 32'd0;
            end
            else if (hit_reg)
            begin
                out_x_reg <= res_reg[0];
                out_y_reg <= res_reg[1];
                out_z_reg <= res_reg[2];
            end
            else
            begin
                out_x_reg <= vec_reg[0];
                out_y_reg <= vec_reg[1];
                out_z_reg <= vec_reg[2];
            end
        end
        unique case (cmd.wb)
            sca_pkg::WB_LOAD_ANG: ang_reg <= ang_sel;
            sca_pkg::WB_DIV_START:
            begin
                neg_reg <= ang_reg[31];
                dvd_reg <= ang_reg[31] ? -ang_reg : ang_reg;
                rem_reg <= 32'd0;
            end
            sca_pkg::WB_DIV_STEP:
            begin
                // one restoring step: remainder stays below the modulus
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                if (shifted >= {2'b00, tpi_reg})
                    rem_reg <= 32'(shifted - {2'b00, tpi_reg});
                else
                    rem_reg <= shifted[31:0];
            end
            sca_pkg::WB_DIV_FIX: ang_reg <= neg_reg ? -rem_reg : rem_reg;
            sca_pkg::WB_ADJ1:
                if (ge_p)
                    ang_reg <= ang_reg - {1'b0, tpi_reg};
            sca_pkg::WB_ADJ2:
                if (le_np)
                    ang_reg <= ang_reg + {1'b0, tpi_reg};
            sca_pkg::WB_X2:
            begin
                x2_reg  <= 64'($signed(prod_reg) >>> FRAC_BITS);
                acc_reg <= 64'(sca_pkg::POLY_TOP);
            end
            sca_pkg::WB_SUM_SET: sum_reg <= prod_reg;
            sca_pkg::WB_SUM_ADD: sum_reg <= sum_add;
            sca_pkg::WB_ACC:
                acc_reg <= 64'($signed(sum_reg) >>> FRAC_BITS) + sca_pkg::poly_coef(cmd.coef_sel);
            sca_pkg::WB_TR:
                tr_reg <= 32'($signed(sum_reg) >>> sca_pkg::COEF_FRAC_BITS);
            sca_pkg::WB_TRIG: trig_reg[cmd.sel] <= nprod;
            sca_pkg::WB_TMP:  tmp_reg <= nprod;
            sca_pkg::WB_VX:   vec_reg[0] <= nprod;
            sca_pkg::WB_VY:   vec_reg[1] <= nprod;
            sca_pkg::WB_VZ:   vec_reg[2] <= nprod;
            sca_pkg::WB_SCAN_CMP:
            begin
                if (match)
                    tgt_reg <= slot_reg;
                if (!valid_reg[slot_reg] && !free_found_reg)
                    free_reg <= slot_reg;
            end
            sca_pkg::WB_AF_START: racc_reg <= 32'd0;
            sca_pkg::WB_AF_ACC:   racc_reg <= racc_reg + nprod;
            sca_pkg::WB_AF_ROW:
            begin
                res_reg[row_reg] <= racc_reg + word_rd_reg;
                racc_reg         <= 32'd0;
            end
            sca_pkg::WB_TGT:
                if (!hit_reg)
                    tgt_reg <= free_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        st.in_valid   = in_valid;
        st.action     = act_reg;
        st.widx_over  = widx_reg > sca_pkg::WIDX_COMMIT;
        st.widx_last  = widx_reg == sca_pkg::WIDX_COMMIT;
        st.need_div   = (ge_p || le_np) && (tpi_reg != '0);
        st.div_last   = dcnt_reg == 5'd31;
        st.hit_now    = match;
        st.slot_last  = slot_reg == SW'(TABLE_ENTRIES - 1);
        st.hit        = hit_reg;
        st.free_found = free_found_reg;
        st.col_last   = col_reg == 2'd2;
        st.row_last   = row_reg == 2'd2;
        st.copy_last  = cnt_reg == sca_pkg::WIDX_COMMIT;
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign out_matched = out_matched_reg;
    assign out_status  = out_status_reg;

endmodule

FILE: design/spherical_to_cartesian_affine.sv
// Channel   | Handshake                   | Payload (lowest bit first)
// s_axis    | s_axis_tvalid/s_axis_tready | tuser: action; tdata: key, radius, phi,
//           |                             |   theta, word_index, word_value, zero pad
// m_axis    | m_axis_tvalid/m_axis_tready | tuser: matched, status; tdata: x, y, z
// cfg       | cfg_we (no wait)            | cfg_addr: register index, cfg_wdata: value
//
// One item at a time, one shared 33x33 multiplier and a serial divider. A transform
// runs four sine evaluations, a modulo reduction for each angle that needs one and a
// key scan over the table slots, followed by the affine step on a hit. A table word is
// staged; a commit adds the scan, a copy of the 12 staged words and the key write.
// Reset clears the table valid bits and the staged words; no clearing pass.
// A waiting result holds the output register; the block stalls only when a second is ready.
module spherical_to_cartesian_affine #(
    parameter int FRAC_BITS     = sca_pkg::FRAC_BITS_DEFAULT,
    parameter int TABLE_ENTRIES = sca_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [167:0]              s_axis_tdata,  // key, radius, phi, theta, word_index, word_value
    input  logic                      s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [95:0]               m_axis_tdata,  // out_x, out_y, out_z
    output logic [2:0]                m_axis_tuser,  // matched, status
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [sca_pkg::CFG_W-1:0] cfg_wdata
);

    sca_pkg::cmd_t  cmd;
    sca_pkg::stat_t st;

    logic signed [31:0] x, y, z;
    logic               matched;
    logic [1:0]         status;

    // sequence each item's multiply, divide, scan and copy steps
    sca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // hold the operands, table and result register
    sca_dp #(
        .FRAC_BITS     (FRAC_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .in_valid      (s_axis_tvalid),
        .in_action     (s_axis_tuser),
        .in_key        (s_axis_tdata[31:0]),
        .in_radius     (s_axis_tdata[63:32]),
        .in_phi        (s_axis_tdata[95:64]),
        .in_theta      (s_axis_tdata[127:96]),
        .in_word_index (s_axis_tdata[131:128]),
        .in_word_value (s_axis_tdata[163:132]),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_x         (x),
        .out_y         (y),
        .out_z         (z),
        .out_matched   (matched),
        .out_status    (status)
    );

    // input transfer only while the controller waits for work
    assign s_axis_tready = cmd.capture;
    assign m_axis_tdata  = {z, y, x};
    assign m_axis_tuser  = {status, matched};

endmodule
